>>> src/fltw_pkg.sv
// ----------------------------------------------------------------------------
// fltw_pkg
// Shared types and constants for the four-level page table walker.
// ----------------------------------------------------------------------------
package fltw_pkg;

    localparam int PA_W    = 52;
    localparam int VA_W    = 48;
    localparam int ENTRY_W = 64;
    localparam int KIND_W  = 2;
    localparam int LEVEL_W = 2;
    localparam int IDX_W   = 9;

    // func codes
    localparam logic FUNC_TRANSLATE = 1'b0;
    localparam logic FUNC_RESPONSE  = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;

    // level whose entry is awaited
    localparam logic [LEVEL_W-1:0] LEVEL_PML4 = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_PDPT = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_PD   = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_PT   = 2'd3;

    // entry bits
    localparam int BIT_PRESENT = 0;
    localparam int BIT_SIZE    = 7;

    typedef struct packed {
        logic               func;
        logic [VA_W-1:0]    virt_addr;
        logic [ENTRY_W-1:0] read_data;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PA_W-1:0]   mem_addr;
        logic [PA_W-1:0]   phys_addr;
        logic              not_present;
    } rsp_t;

    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level;
        logic [VA_W-1:0]    vaddr;
    } walk_t;

endpackage

>>> src/fltw_req_if.sv
// ----------------------------------------------------------------------------
// fltw_req_if
// Input channel: translate requests and table read responses.
// ----------------------------------------------------------------------------
interface fltw_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [fltw_pkg::VA_W-1:0]    virt_addr;
    logic [fltw_pkg::ENTRY_W-1:0] read_data;

    modport source (output valid, func, virt_addr, read_data, input ready);
    modport sink   (input valid, func, virt_addr, read_data, output ready);
endinterface

>>> src/fltw_rsp_if.sv
// ----------------------------------------------------------------------------
// fltw_rsp_if
// Output channel: read requests, finished translations and rejects.
// ----------------------------------------------------------------------------
interface fltw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [fltw_pkg::KIND_W-1:0] kind;
    logic [fltw_pkg::PA_W-1:0]   mem_addr;
    logic [fltw_pkg::PA_W-1:0]   phys_addr;
    logic                        not_present;

    modport source (output valid, kind, mem_addr, phys_addr, not_present, input ready);
    modport sink   (input valid, kind, mem_addr, phys_addr, not_present, output ready);
endinterface

>>> src/fltw_cfg_if.sv
// ----------------------------------------------------------------------------
// fltw_cfg_if
// Configuration write channel for the page table base.
// ----------------------------------------------------------------------------
interface fltw_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [fltw_pkg::PA_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> src/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level x86-64 page table walker with an external table read loop.
// ----------------------------------------------------------------------------
// Each beat on req is either a translate request (func 0) or a table entry
// coming back from memory (func 1); each produces exactly one beat on rsp:
// a read request for the next entry (kind 0), a finished translation (kind 1,
// not_present set on a fault or when the table base is zero), or a reject
// (kind 2) for a request while a walk is running or a response while idle.
// The block holds one beat in an input register and one in an output
// register with a single combinational walk step between them, so it takes
// one beat per cycle while rsp.ready is high. An accepted beat moves from
// the input register to the output register and leaves on rsp from there.
// A rsp beat held by a low rsp.ready stalls req once the input register is
// also full. The caller closes the loop: a kind 0 beat's mem_addr is read
// and the entry is sent back on req. Write page_table_base on cfg only while
// idle; it is sampled when a walk starts. cfg is always ready.
// ----------------------------------------------------------------------------
module four_level_page_table_walker
(
    input  logic       clk,
    input  logic       rst_n,
    fltw_req_if.sink   req,
    fltw_rsp_if.source rsp,
    fltw_cfg_if.sink   cfg
);

    logic                       in_valid_reg;
    fltw_pkg::req_t             in_item_reg;
    logic                       out_valid_reg;
    fltw_pkg::rsp_t             out_item_reg;
    fltw_pkg::walk_t            walk_reg;
    fltw_pkg::walk_t            walk_next;
    fltw_pkg::rsp_t             step_result;
    logic [fltw_pkg::PA_W-1:0]  base_reg;
    logic                       advance;

    // The step fires when the output slot is free or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    fltw_step u_step
    (
        .item      (in_item_reg),
        .walk      (walk_reg),
        .base      (base_reg),
        .result    (step_result),
        .walk_next (walk_next)
    );

    // Base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            base_reg <= cfg.data;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.func      <= req.func;
            in_item_reg.virt_addr <= req.virt_addr;
            in_item_reg.read_data <= req.read_data;
        end
    end

    // Walk state: updated as each beat leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg <= '0;
        end
        else if (advance)
        begin
            walk_reg <= walk_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_item_reg <= step_result;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_item_reg.kind;
    assign rsp.mem_addr    = out_item_reg.mem_addr;
    assign rsp.phys_addr   = out_item_reg.phys_addr;
    assign rsp.not_present = out_item_reg.not_present;

endmodule

>>> src/fltw_step.sv
// ----------------------------------------------------------------------------
// fltw_step
// One walk step: decodes a beat against the walk state, forms the result
// and the next walk state.
// ----------------------------------------------------------------------------
module fltw_step
(
    input  fltw_pkg::req_t             item,
    input  fltw_pkg::walk_t            walk,
    input  logic [fltw_pkg::PA_W-1:0]  base,
    output fltw_pkg::rsp_t             result,
    output fltw_pkg::walk_t            walk_next
);

    logic [fltw_pkg::PA_W-13:0]    table_pfn;
    logic [fltw_pkg::LEVEL_W-1:0]  idx_level;
    logic [fltw_pkg::VA_W-1:0]     idx_va;
    logic [fltw_pkg::IDX_W-1:0]    idx;
    logic [fltw_pkg::ENTRY_W-1:0]  e;

    assign e = item.read_data;

    // Table index for the level being read next
    always_comb
    begin
        unique case (idx_level)
            fltw_pkg::LEVEL_PML4: idx = idx_va[47:39];
            fltw_pkg::LEVEL_PDPT: idx = idx_va[38:30];
            fltw_pkg::LEVEL_PD:   idx = idx_va[29:21];
            fltw_pkg::LEVEL_PT:   idx = idx_va[20:12];
            default:              idx = idx_va[20:12];
        endcase
    end

    always_comb
    begin
        result    = '0;
        walk_next = walk;
        table_pfn = base[51:12];
        idx_level = fltw_pkg::LEVEL_PML4;
        idx_va    = item.virt_addr;

        if (item.func == fltw_pkg::FUNC_TRANSLATE)
        begin
            if (walk.busy)
            begin
                result.kind = fltw_pkg::KIND_REJECT;
            end
            else if (base[51:12] == '0)
            begin
                result.kind        = fltw_pkg::KIND_DONE;
                result.not_present = 1'b1;
            end
            else
            begin
                walk_next.busy  = 1'b1;
                walk_next.level = fltw_pkg::LEVEL_PML4;
                walk_next.vaddr = item.virt_addr;
                result.kind     = fltw_pkg::KIND_READ;
                result.mem_addr = {table_pfn, idx, 3'b000};
            end
        end
        else if (!walk.busy)
        begin
            result.kind = fltw_pkg::KIND_REJECT;
        end
        else
        begin
            idx_va    = walk.vaddr;
            idx_level = walk.level + 2'd1;
            table_pfn = e[51:12];
            if (!e[fltw_pkg::BIT_PRESENT])
            begin
                walk_next.busy     = 1'b0;
                walk_next.level    = fltw_pkg::LEVEL_PML4;
                result.kind        = fltw_pkg::KIND_DONE;
                result.not_present = 1'b1;
            end
            else if (walk.level == fltw_pkg::LEVEL_PDPT && e[fltw_pkg::BIT_SIZE])
            begin
                walk_next.busy   = 1'b0;
                walk_next.level  = fltw_pkg::LEVEL_PML4;
                result.kind      = fltw_pkg::KIND_DONE;
                result.phys_addr = {e[51:30], walk.vaddr[29:0]};
            end
            else if (walk.level == fltw_pkg::LEVEL_PD && e[fltw_pkg::BIT_SIZE])
            begin
                walk_next.busy   = 1'b0;
                walk_next.level  = fltw_pkg::LEVEL_PML4;
                result.kind      = fltw_pkg::KIND_DONE;
                result.phys_addr = {e[51:21], walk.vaddr[20:0]};
            end
            else if (walk.level == fltw_pkg::LEVEL_PT)
            begin
                walk_next.busy   = 1'b0;
                walk_next.level  = fltw_pkg::LEVEL_PML4;
                result.kind      = fltw_pkg::KIND_DONE;
                result.phys_addr = {e[51:12], walk.vaddr[11:0]};
            end
            else
            begin
                walk_next.level = idx_level;
                result.kind     = fltw_pkg::KIND_READ;
                result.mem_addr = {table_pfn, idx, 3'b000};
            end
        end
    end

endmodule
